FILE: rtl/kgi_pkg.sv
// Shared constants, record layout and controller/datapath command types.
package kgi_pkg;

    localparam int MAX_KEYS  = 16;
    localparam int KEY_AW    = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int TIME_W    = 17;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 4;
    localparam int FRAC_W    = 17;
    localparam int DIV_STEPS = 17;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int SQ_W      = 2 * FRAC_W;
    localparam int COEF_W    = FRAC_W + 1;
    localparam int NUM_W     = SQ_W + COEF_W;
    localparam int DIFF_W    = VAL_W + 1;
    localparam int PROD_W    = DIFF_W + COEF_W;
    localparam int SUM_W     = VAL_W + 4;

    localparam logic [TIME_W-1:0] ONE_Q16   = TIME_W'(65536);
    localparam logic [COEF_W-1:0] SMOOTH_3  = COEF_W'(196608);
    localparam logic [NUM_W-1:0]  NUM_HALF  = NUM_W'(64'h8000_0000);
    localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(2);

    typedef enum logic [1:0] {
        K_RESET = 2'd0,
        K_ADD   = 2'd1,
        K_EVAL  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [TIME_W-1:0]       tm;
        logic signed [VAL_W-1:0] vx;
        logic signed [VAL_W-1:0] vy;
        logic signed [VAL_W-1:0] vz;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef enum logic [2:0] {
        WS_LEFT, WS_RIGHT, WS_KEY0, WS_LAST, WS_INS, WS_MOVE
    } t_wsel;

    typedef enum logic [1:0] {
        RS_ZERO, RS_LAST, RS_IDX, RS_POSM1
    } t_rsel;

    typedef enum logic [2:0] {
        RES_ZERO, RES_IDX, RES_FULL, RES_END, RES_BLEND
    } t_res;

    typedef struct packed {
        logic       cap_item;
        logic       zero_vals;
        logic       ram_we;
        t_wsel      wsel;
        logic       ram_re;
        t_rsel      rsel;
        logic       cnt_two;
        logic       cnt_inc;
        logic       pos_load;
        logic       pos_dec;
        logic       idx_clr;
        logic       idx_inc;
        logic       shift_rec;
        logic       div_start;
        logic       div_step;
        logic       sq_step;
        logic       cub_step;
        logic       w_step;
        logic       bl_mul;
        logic       bl_acc;
        logic [1:0] ch;
        logic       load_out;
        t_res       res;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  t_zero;
        logic  t_ge_one;
        logic  full;
        logic  scan_more;
        logic  move_more;
        logic  div_last;
    } t_stat;

endpackage

FILE: rtl/kgi_in_if.sv
// Request channel: valid/ready handshake with the request fields.
interface kgi_in_if import kgi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic [TIME_W-1:0]        key_time;
    logic signed [VAL_W-1:0]  value_x;
    logic signed [VAL_W-1:0]  value_y;
    logic signed [VAL_W-1:0]  value_z;

    modport source(output valid, kind, key_time, value_x, value_y, value_z, input ready);
    modport sink(input valid, kind, key_time, value_x, value_y, value_z, output ready);
endinterface

FILE: rtl/kgi_out_if.sv
// Result channel: valid/ready handshake with the result fields.
interface kgi_out_if import kgi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         key_index;
    logic                     table_full;
    logic signed [VAL_W-1:0]  out_x;
    logic signed [VAL_W-1:0]  out_y;
    logic signed [VAL_W-1:0]  out_z;

    modport source(output valid, key_index, table_full, out_x, out_y, out_z, input ready);
    modport sink(input valid, key_index, table_full, out_x, out_y, out_z, output ready);
endinterface

FILE: rtl/kgi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kgi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/kgi_ctrl.sv
// Sequencer for table init, key insert, bracket scan, divide and blend.
module kgi_ctrl import kgi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_IDLE, S_DISP, S_RST1, S_ERD, S_IRD, S_ICHK,
        S_SRD, S_SCHK, S_DIVI, S_DIV, S_SQ, S_CUB, S_W, S_BMUL, S_BACC, S_DONE
    } t_state;

    t_state     r_state, n_state;
    t_res       r_res, n_res;
    logic [1:0] r_ch, n_ch;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_ch        = r_ch;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = '0;
        cmd.ch      = r_ch;
        cmd.res     = r_res;
        case (r_state)
            S_INIT0: begin
                cmd.ram_we    = 1'b1;
                cmd.wsel      = WS_LEFT;
                cmd.zero_vals = 1'b1;
                cmd.cnt_two   = 1'b1;
                n_state       = S_INIT1;
            end
            S_INIT1: begin
                cmd.ram_we    = 1'b1;
                cmd.wsel      = WS_RIGHT;
                cmd.zero_vals = 1'b1;
                n_state       = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap_item = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.kind)
                    K_RESET: begin
                        cmd.ram_we  = 1'b1;
                        cmd.wsel    = WS_LEFT;
                        cmd.cnt_two = 1'b1;
                        n_res       = RES_ZERO;
                        n_state     = S_RST1;
                    end
                    K_ADD: begin
                        n_res = RES_IDX;
                        if (i_stat.full) begin
                            n_res   = RES_FULL;
                            n_state = S_DONE;
                        end else if (i_stat.t_zero) begin
                            cmd.ram_we = 1'b1;
                            cmd.wsel   = WS_KEY0;
                            n_state    = S_DONE;
                        end else if (i_stat.t_ge_one) begin
                            cmd.ram_we = 1'b1;
                            cmd.wsel   = WS_LAST;
                            n_state    = S_DONE;
                        end else begin
                            cmd.pos_load = 1'b1;
                            n_state      = S_IRD;
                        end
                    end
                    K_EVAL: begin
                        if (i_stat.t_zero || i_stat.t_ge_one) begin
                            cmd.ram_re = 1'b1;
                            cmd.rsel   = i_stat.t_zero ? RS_ZERO : RS_LAST;
                            n_res      = RES_END;
                            n_state    = S_ERD;
                        end else begin
                            cmd.idx_clr = 1'b1;
                            n_state     = S_SRD;
                        end
                    end
                    default: begin
                        n_res   = RES_ZERO;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RST1: begin
                cmd.ram_we = 1'b1;
                cmd.wsel   = WS_RIGHT;
                n_state    = S_DONE;
            end
            S_ERD: begin
                cmd.shift_rec = 1'b1;
                n_state       = S_DONE;
            end
            S_IRD: begin
                cmd.ram_re = 1'b1;
                cmd.rsel   = RS_POSM1;
                n_state    = S_ICHK;
            end
            S_ICHK: begin
                cmd.ram_we = 1'b1;
                if (i_stat.move_more) begin
                    cmd.wsel    = WS_MOVE;
                    cmd.pos_dec = 1'b1;
                    n_state     = S_IRD;
                end else begin
                    cmd.wsel    = WS_INS;
                    cmd.cnt_inc = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_SRD: begin
                cmd.ram_re = 1'b1;
                cmd.rsel   = RS_IDX;
                n_state    = S_SCHK;
            end
            S_SCHK: begin
                cmd.shift_rec = 1'b1;
                if (i_stat.scan_more) begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_SRD;
                end else begin
                    n_state = S_DIVI;
                end
            end
            S_DIVI: begin
                cmd.div_start = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                cmd.sq_step = 1'b1;
                n_state     = S_CUB;
            end
            S_CUB: begin
                cmd.cub_step = 1'b1;
                n_state      = S_W;
            end
            S_W: begin
                cmd.w_step = 1'b1;
                n_ch       = 2'd0;
                n_state    = S_BMUL;
            end
            S_BMUL: begin
                cmd.bl_mul = 1'b1;
                n_state    = S_BACC;
            end
            S_BACC: begin
                cmd.bl_acc = 1'b1;
                if (r_ch == 2'd2) begin
                    n_res   = RES_BLEND;
                    n_state = S_DONE;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = S_BMUL;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT0;
            r_res       <= RES_ZERO;
            r_ch        <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
endmodule

FILE: rtl/kgi_dp.sv
// Datapath: key table, insert and scan pointers, fraction divider, blend unit.
module kgi_dp import kgi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic                    i_cfg_wr_data,
    input  logic [1:0]              i_kind,
    input  logic [TIME_W-1:0]       i_key_time,
    input  logic signed [VAL_W-1:0] i_value_x,
    input  logic signed [VAL_W-1:0] i_value_y,
    input  logic signed [VAL_W-1:0] i_value_z,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    output logic [IDX_W-1:0]        o_key_index,
    output logic                    o_table_full,
    output logic signed [VAL_W-1:0] o_out_x,
    output logic signed [VAL_W-1:0] o_out_y,
    output logic signed [VAL_W-1:0] o_out_z
);
    logic                    r_smooth;
    logic [1:0]              r_kind;
    logic [TIME_W-1:0]       r_t;
    logic signed [VAL_W-1:0] r_vx, r_vy, r_vz;
    logic [CNT_W-1:0]        r_cnt;
    logic [KEY_AW-1:0]       r_pos, r_idx, r_kidx;
    t_rec                    r_prev, r_cur;
    logic [FRAC_W-1:0]       r_rem, r_d, r_q, r_w;
    logic                    r_nb, r_guard;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [SQ_W-1:0]         r_sq;
    logic [COEF_W-1:0]       r_coef;
    logic [NUM_W-1:0]        r_num;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VAL_W-1:0] r_bl [3];
    logic [IDX_W-1:0]        r_o_idx, n_o_idx;
    logic                    r_o_full, n_o_full;
    logic signed [VAL_W-1:0] r_o_x, r_o_y, r_o_z;
    logic signed [VAL_W-1:0] n_o_x, n_o_y, n_o_z;

    logic [KEY_AW-1:0]       last, waddr, raddr;
    t_rec                    wrec, rdata;
    logic signed [VAL_W-1:0] lv, rv, a_v, b_v;
    logic [FRAC_W:0]         shifted;
    logic                    ge;
    logic [FRAC_W-1:0]       frac;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] rnd;
    logic signed [SUM_W-1:0] sum;
    logic signed [VAL_W-1:0] sat;

    assign last = KEY_AW'(r_cnt - CNT_W'(1));
    assign lv   = i_cmd.zero_vals ? '0 : r_vx;
    assign rv   = i_cmd.zero_vals ? '0 : r_vy;

    always_comb begin
        waddr = '0;
        wrec  = '{tm: '0, vx: lv, vy: lv, vz: lv};
        case (i_cmd.wsel)
            WS_LEFT: begin
                waddr = '0;
                wrec  = '{tm: '0, vx: lv, vy: lv, vz: lv};
            end
            WS_RIGHT: begin
                waddr = KEY_AW'(1);
                wrec  = '{tm: ONE_Q16, vx: rv, vy: rv, vz: rv};
            end
            WS_KEY0: begin
                waddr = '0;
                wrec  = '{tm: '0, vx: r_vx, vy: r_vy, vz: r_vz};
            end
            WS_LAST: begin
                waddr = last;
                wrec  = '{tm: ONE_Q16, vx: r_vx, vy: r_vy, vz: r_vz};
            end
            WS_INS: begin
                waddr = r_pos;
                wrec  = '{tm: r_t, vx: r_vx, vy: r_vy, vz: r_vz};
            end
            WS_MOVE: begin
                waddr = r_pos;
                wrec  = rdata;
            end
            default: begin
                waddr = '0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.rsel)
            RS_ZERO:  raddr = '0;
            RS_LAST:  raddr = last;
            RS_IDX:   raddr = r_idx;
            RS_POSM1: raddr = r_pos - KEY_AW'(1);
            default:  raddr = '0;
        endcase
    end

    kgi_ram #(
        .WIDTH(REC_W),
        .DEPTH(MAX_KEYS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.ram_we),
        .i_waddr(waddr),
        .i_wdata(wrec),
        .i_re   (i_cmd.ram_re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign shifted = {r_rem, r_nb};
    assign ge      = (shifted >= {1'b0, r_d});
    assign frac    = !r_guard ? '0 : ((r_q > ONE_Q16) ? ONE_Q16 : r_q);

    always_comb begin
        case (i_cmd.ch)
            2'd0:    begin a_v = r_prev.vx; b_v = r_cur.vx; end
            2'd1:    begin a_v = r_prev.vy; b_v = r_cur.vy; end
            default: begin a_v = r_prev.vz; b_v = r_cur.vz; end
        endcase
    end

    assign diff = DIFF_W'(b_v) - DIFF_W'(a_v);
    assign rnd  = r_prod + PROD_W'(32768);
    assign sum  = SUM_W'(a_v) + SUM_W'(rnd >>> 16);

    always_comb begin
        if (sum > SUM_W'(64'sh7FFF_FFFF)) begin
            sat = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (sum < -SUM_W'(64'sh8000_0000)) begin
            sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sat = VAL_W'(sum);
        end
    end

    always_comb begin
        n_o_idx  = '0;
        n_o_full = 1'b0;
        n_o_x    = '0;
        n_o_y    = '0;
        n_o_z    = '0;
        case (i_cmd.res)
            RES_IDX:  n_o_idx = IDX_W'(r_kidx);
            RES_FULL: n_o_full = 1'b1;
            RES_END: begin
                n_o_x = r_cur.vx;
                n_o_y = r_cur.vy;
                n_o_z = r_cur.vz;
            end
            RES_BLEND: begin
                n_o_x = r_bl[0];
                n_o_y = r_bl[1];
                n_o_z = r_bl[2];
            end
            default: n_o_idx = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= 1'b0;
            r_cnt    <= CNT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_smooth <= i_cfg_wr_data;
            end
            if (i_cmd.cnt_two) begin
                r_cnt <= CNT_RESET;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_kind <= i_kind;
            r_t    <= i_key_time;
            r_vx   <= i_value_x;
            r_vy   <= i_value_y;
            r_vz   <= i_value_z;
        end
        if (i_cmd.ram_we) begin
            case (i_cmd.wsel)
                WS_KEY0: r_kidx <= '0;
                WS_LAST: r_kidx <= last;
                WS_INS:  r_kidx <= r_pos;
                default: r_kidx <= r_kidx;
            endcase
        end
        if (i_cmd.pos_load) begin
            r_pos <= KEY_AW'(r_cnt);
        end else if (i_cmd.pos_dec) begin
            r_pos <= r_pos - KEY_AW'(1);
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + KEY_AW'(1);
        end
        if (i_cmd.shift_rec) begin
            r_prev <= r_cur;
            r_cur  <= rdata;
        end
        if (i_cmd.div_start) begin
            r_guard <= (r_cur.tm > r_prev.tm) && (r_t >= r_prev.tm);
            r_d     <= r_cur.tm - r_prev.tm;
            r_rem   <= (r_t - r_prev.tm) >> 1;
            r_nb    <= r_t[0] ^ r_prev.tm[0];
            r_q     <= '0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= ge ? FRAC_W'(shifted - {1'b0, r_d}) : FRAC_W'(shifted);
            r_q    <= {r_q[FRAC_W-2:0], ge};
            r_nb   <= 1'b0;
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
        if (i_cmd.sq_step) begin
            r_sq   <= SQ_W'(frac) * SQ_W'(frac);
            r_coef <= SMOOTH_3 - {frac, 1'b0};
        end
        if (i_cmd.cub_step) begin
            r_num <= NUM_W'(r_sq) * NUM_W'(r_coef);
        end
        if (i_cmd.w_step) begin
            r_w <= r_smooth ? FRAC_W'((r_num + NUM_HALF) >> 32) : frac;
        end
        if (i_cmd.bl_mul) begin
            r_prod <= PROD_W'(diff) * PROD_W'($signed({1'b0, r_w}));
        end
        if (i_cmd.bl_acc) begin
            r_bl[i_cmd.ch] <= sat;
        end
        if (i_cmd.load_out) begin
            r_o_idx  <= n_o_idx;
            r_o_full <= n_o_full;
            r_o_x    <= n_o_x;
            r_o_y    <= n_o_y;
            r_o_z    <= n_o_z;
        end
    end

    assign o_stat.kind      = t_kind'(r_kind);
    assign o_stat.t_zero    = (r_t == '0);
    assign o_stat.t_ge_one  = (r_t >= ONE_Q16);
    assign o_stat.full      = (r_cnt >= CNT_W'(MAX_KEYS));
    assign o_stat.scan_more = (r_idx == '0) || ((r_idx < last) && (rdata.tm < r_t));
    assign o_stat.move_more = (rdata.tm > r_t);
    assign o_stat.div_last  = (r_dcnt == DCNT_W'(DIV_STEPS - 1));

    assign o_key_index  = r_o_idx;
    assign o_table_full = r_o_full;
    assign o_out_x      = r_o_x;
    assign o_out_y      = r_o_y;
    assign o_out_z      = r_o_z;
endmodule

FILE: rtl/keyframe_gradient_interpolator_core.sv
// Keyframe gradient interpolator: sorted key table with linear/smoothstep evaluation.
// One request at a time. A table reset rewrites the two default end keys, an
// evaluation at an end reads one end key, an insert moves each key later than the
// new time up by one entry, and an evaluation between the ends scans the table up
// to the upper bracketing key: the key scan reads one table entry at a time, the
// fraction comes from a 17-step restoring divider, and the three channels share
// one blend multiplier. After reset the block writes the default end keys before
// it takes requests. A finished result waits in the output register while the
// next request is taken.
module keyframe_gradient_interpolator_core import kgi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    kgi_in_if.sink      i_req,
    kgi_out_if.source   o_rsp
);
    t_cmd  cmd;
    t_stat stat;

    kgi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    kgi_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_kind       (i_req.kind),
        .i_key_time   (i_req.key_time),
        .i_value_x    (i_req.value_x),
        .i_value_y    (i_req.value_y),
        .i_value_z    (i_req.value_z),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_key_index  (o_rsp.key_index),
        .o_table_full (o_rsp.table_full),
        .o_out_x      (o_rsp.out_x),
        .o_out_y      (o_rsp.out_y),
        .o_out_z      (o_rsp.out_z)
    );
endmodule

FILE: rtl/kgi_checker.sv
// Port-level checks for the interpolator, bound to the top level.
module kgi_checker import kgi_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [IDX_W-1:0]        i_key_index,
    input logic                    i_table_full,
    input logic signed [VAL_W-1:0] i_out_x,
    input logic signed [VAL_W-1:0] i_out_y,
    input logic signed [VAL_W-1:0] i_out_z
);
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_one_request_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while another is in progress");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_table_full) |->
            (i_key_index == '0 && i_out_x == '0 && i_out_y == '0 && i_out_z == '0))
        else $error("refused add carries nonzero fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_key_index) && $stable(i_out_x)))
        else $error("stalled result changed");
endmodule

bind keyframe_gradient_interpolator_core kgi_checker u_kgi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_key_index (o_rsp.key_index),
    .i_table_full(o_rsp.table_full),
    .i_out_x     (o_rsp.out_x),
    .i_out_y     (o_rsp.out_y),
    .i_out_z     (o_rsp.out_z)
);
